// File: hdl/light_macro_sequencer_core_defines.svh
// assertion macros for the light macro sequencer
`ifndef LIGHT_MACRO_SEQUENCER_CORE_DEFINES_SVH
`define LIGHT_MACRO_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LMS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lms check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off while arst_n is low
`define LMS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lms check failed: next-cycle rule");

`endif

// File: hdl/lms_pkg.sv
package lms_pkg;

	// store sizes
	localparam int SCRIPT_DEPTH = 256;
	localparam int REG_COUNT    = 16;
	localparam int DUMP_MAX     = 16;
	localparam int DUMP_N       = (REG_COUNT < DUMP_MAX) ? REG_COUNT : DUMP_MAX;
	localparam int SA_W         = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
	localparam int RA_W         = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	// command codes
	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_START = 2'd1;
	localparam logic [1:0] FN_STOP  = 2'd2;
	localparam logic [1:0] FN_STEP  = 2'd3;

	// opcodes
	localparam logic [7:0] OP_END        = 8'h00;
	localparam logic [7:0] OP_SLEEP      = 8'h01;
	localparam logic [7:0] OP_EXECUTE    = 8'h03;
	localparam logic [7:0] OP_LOAD       = 8'h10;
	localparam logic [7:0] OP_LOAD_ARRAY = 8'h11;
	localparam logic [7:0] OP_MOVE       = 8'h12;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] address;
		logic [7:0] data;
		logic       ms_tick;
	} lms_cmd_t;

	typedef struct packed {
		logic       running;
		logic       sleeping;
		logic       error_code;
		logic [7:0] program_counter;
		logic       dump_valid;
		logic [3:0] reg_index;
		logic [7:0] reg_value;
		logic       last;
	} lms_res_t;

endpackage

// File: hdl/lms_req_if.sv
interface lms_req_if;
	import lms_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] address;
	logic [7:0] data;
	logic       ms_tick;

	modport source (output valid, func, address, data, ms_tick, input ready);
	modport sink (input valid, func, address, data, ms_tick, output ready);
endinterface

// File: hdl/lms_rsp_if.sv
interface lms_rsp_if;
	import lms_pkg::*;

	logic       valid;
	logic       ready;
	logic       running;
	logic       sleeping;
	logic       error_code;
	logic [7:0] program_counter;
	logic       dump_valid;
	logic [3:0] reg_index;
	logic [7:0] reg_value;
	logic       last;

	modport source (output valid, running, sleeping, error_code, program_counter,
		dump_valid, reg_index, reg_value, last, input ready);
	modport sink (input valid, running, sleeping, error_code, program_counter,
		dump_valid, reg_index, reg_value, last, output ready);
endinterface

// File: hdl/lms_ram.sv
module lms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hdl/lms_seq.sv
module lms_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_vld,
	input  lms_pkg::lms_cmd_t cmd,
	output logic              cmd_rdy,
	input  logic              loop_mode,
	output logic              res_vld,
	output lms_pkg::lms_res_t res,
	input  logic              res_rdy
);
	import lms_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_OP      = 4'd1;
	localparam logic [3:0] ST_SL_HI   = 4'd2;
	localparam logic [3:0] ST_SL_LO   = 4'd3;
	localparam logic [3:0] ST_LD_ADR  = 4'd4;
	localparam logic [3:0] ST_LD_VAL  = 4'd5;
	localparam logic [3:0] ST_LA_ADR  = 4'd6;
	localparam logic [3:0] ST_LA_SIZE = 4'd7;
	localparam logic [3:0] ST_LA_DATA = 4'd8;
	localparam logic [3:0] ST_DUMP    = 4'd9;
	localparam logic [3:0] ST_STAT    = 4'd10;

	logic [3:0]  state_q;
	logic [7:0]  pc_q;
	logic        run_q;
	logic        sleep_q;
	logic        err_q;
	logic [15:0] cnt_q;
	logic [15:0] target_q;
	logic [7:0]  thi_q;
	logic [7:0]  adr_q;
	logic [7:0]  size_q;
	logic [7:0]  la_i_q;
	logic [8:0]  tgt_q;
	logic [3:0]  dump_k_q;
	logic        oor_q;
	logic        rvld_q;
	logic [REG_COUNT-1:0] reg_vld_q;

	logic            s_we;
	logic            s_re;
	logic [SA_W-1:0] s_waddr;
	logic [7:0]      s_rdata;
	logic            r_we;
	logic [RA_W-1:0] r_waddr;
	logic [7:0]      r_wdata;
	logic            r_re;
	logic [RA_W-1:0] r_raddr;
	logic [7:0]      r_rdata;

	logic [7:0]  byte_cur;
	logic [15:0] cnt_nxt;
	logic        go;
	logic        la_last;
	logic        dump_last;
	logic        wr_in_range;

	// script store and register file
	lms_ram #(.WIDTH(8), .DEPTH(SCRIPT_DEPTH)) u_script (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (cmd.data),
		.re    (s_re),
		.raddr (pc_q[SA_W-1:0]),
		.rdata (s_rdata)
	);

	lms_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	// fetched byte, zero past the end of the store
	assign byte_cur    = oor_q ? 8'h00 : s_rdata;
	assign s_waddr     = cmd.address[SA_W-1:0];
	assign wr_in_range = {1'b0, cmd.address} < 9'(SCRIPT_DEPTH);

	// sleep tick with saturation
	assign cnt_nxt = (cmd.ms_tick && (cnt_q != 16'hFFFF)) ? cnt_q + 16'd1 : cnt_q;
	assign go      = !sleep_q || (cnt_nxt >= target_q);

	assign la_last   = (la_i_q == size_q - 8'd1);
	assign dump_last = (dump_k_q == 4'(DUMP_N - 1));
	assign cmd_rdy   = (state_q == ST_IDLE);

	// memory port control
	always_comb begin
		s_we    = 1'b0;
		s_re    = 1'b0;
		r_we    = 1'b0;
		r_waddr = RA_W'(tgt_q);
		r_wdata = byte_cur;
		r_re    = 1'b0;
		r_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_vld) begin
					if (cmd.func == FN_WRITE) begin
						s_we = wr_in_range;
					end else if (cmd.func == FN_STEP) begin
						s_re = run_q && go;
					end
				end
			end
			ST_OP: begin
				if (byte_cur == OP_SLEEP || byte_cur == OP_LOAD ||
				    byte_cur == OP_LOAD_ARRAY) begin
					s_re = 1'b1;
				end
				if (byte_cur == OP_EXECUTE) begin
					r_re = 1'b1;
				end
			end
			ST_SL_HI, ST_LD_ADR, ST_LA_ADR: begin
				s_re = 1'b1;
			end
			ST_LA_SIZE: begin
				s_re = (byte_cur != 8'h00);
			end
			ST_LA_DATA: begin
				r_we = tgt_q < 9'(REG_COUNT);
				s_re = !la_last;
			end
			ST_LD_VAL: begin
				r_we    = {1'b0, adr_q} < 9'(REG_COUNT);
				r_waddr = RA_W'(adr_q);
			end
			ST_DUMP: begin
				r_re    = res_rdy && !dump_last;
				r_raddr = RA_W'(dump_k_q + 4'd1);
			end
			default: begin
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			run_q     <= 1'b0;
			sleep_q   <= 1'b0;
			err_q     <= 1'b0;
			cnt_q     <= '0;
			target_q  <= '0;
			thi_q     <= '0;
			adr_q     <= '0;
			size_q    <= '0;
			la_i_q    <= '0;
			tgt_q     <= '0;
			dump_k_q  <= '0;
			oor_q     <= 1'b0;
			rvld_q    <= 1'b0;
			reg_vld_q <= '0;
		end else begin
			// fetch advances the program counter
			if (s_re) begin
				pc_q  <= pc_q + 8'd1;
				oor_q <= !({1'b0, pc_q} < 9'(SCRIPT_DEPTH));
			end
			if (r_we) begin
				reg_vld_q[r_waddr] <= 1'b1;
			end
			if (r_re) begin
				rvld_q <= reg_vld_q[r_raddr];
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_vld) begin
						state_q <= ((cmd.func == FN_STEP) && run_q && go) ? ST_OP : ST_STAT;
						case (cmd.func)
							FN_START: begin
								run_q   <= 1'b1;
								sleep_q <= 1'b0;
								err_q   <= 1'b0;
								pc_q    <= '0;
							end
							FN_STOP: begin
								run_q   <= 1'b0;
								sleep_q <= 1'b0;
							end
							FN_STEP: begin
								if (run_q && sleep_q) begin
									cnt_q <= cnt_nxt;
									if (go) begin
										sleep_q <= 1'b0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_OP: begin
					case (byte_cur)
						OP_END: begin
							if (!loop_mode) begin
								run_q <= 1'b0;
							end
							pc_q    <= '0;
							state_q <= ST_STAT;
						end
						OP_SLEEP:      state_q <= ST_SL_HI;
						OP_EXECUTE: begin
							dump_k_q <= '0;
							state_q  <= ST_DUMP;
						end
						OP_LOAD:       state_q <= ST_LD_ADR;
						OP_LOAD_ARRAY: state_q <= ST_LA_ADR;
						OP_MOVE: begin
							pc_q    <= pc_q + 8'd2;
							state_q <= ST_STAT;
						end
						default: begin
							err_q   <= 1'b1;
							run_q   <= 1'b0;
							state_q <= ST_STAT;
						end
					endcase
				end
				ST_SL_HI: begin
					thi_q   <= byte_cur;
					state_q <= ST_SL_LO;
				end
				ST_SL_LO: begin
					target_q <= {thi_q, byte_cur};
					cnt_q    <= '0;
					sleep_q  <= 1'b1;
					state_q  <= ST_STAT;
				end
				ST_LD_ADR: begin
					adr_q   <= byte_cur;
					state_q <= ST_LD_VAL;
				end
				ST_LD_VAL: begin
					state_q <= ST_STAT;
				end
				ST_LA_ADR: begin
					adr_q   <= byte_cur;
					state_q <= ST_LA_SIZE;
				end
				ST_LA_SIZE: begin
					size_q  <= byte_cur;
					tgt_q   <= {1'b0, adr_q};
					la_i_q  <= '0;
					state_q <= (byte_cur == 8'h00) ? ST_STAT : ST_LA_DATA;
				end
				ST_LA_DATA: begin
					tgt_q  <= tgt_q + 9'd1;
					la_i_q <= la_i_q + 8'd1;
					if (la_last) begin
						state_q <= ST_STAT;
					end
				end
				ST_DUMP: begin
					if (res_rdy) begin
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							dump_k_q <= dump_k_q + 4'd1;
						end
					end
				end
				ST_STAT: begin
					if (res_rdy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat
	assign res_vld             = (state_q == ST_STAT) || (state_q == ST_DUMP);
	assign res.running         = run_q;
	assign res.sleeping        = sleep_q;
	assign res.error_code      = err_q;
	assign res.program_counter = pc_q;
	assign res.dump_valid      = (state_q == ST_DUMP);
	assign res.reg_index       = (state_q == ST_DUMP) ? dump_k_q : 4'd0;
	assign res.reg_value       = ((state_q == ST_DUMP) && rvld_q) ? r_rdata : 8'h00;
	assign res.last            = (state_q == ST_STAT) || dump_last;
endmodule

// File: hdl/light_macro_sequencer_core.sv
// Light macro sequencer: runs a byte-code light script held in a script store.
// req carries one command beat (func, address, data, ms_tick): a script byte
// write, start, stop or step. rsp carries result beats with the status after
// the command; an execute instruction instead yields one beat per register
// (up to 16), the final one marked by last. cfg_wr_en/cfg_wr_data set
// loop_mode; write it only while the block is idle.
// One command is in work at a time; req.ready is high only when idle.
// Write, start, stop and idle step go straight to a status beat in the result register.
// Executing step: end/move, load, sleep and load array end in a status beat; load array
// makes one register write per cycle (bound by the single script read port), and
// execute yields one beat per dumped register. The script store is fetched one byte
// at a time through its registered read port.
// Reset clears run, sleep, error, program counter, loop_mode and the register
// file (valid bits); the script store is undefined until written.
// When rsp.ready is low the result register holds its beat and the sequencer
// waits, so no beat is lost; a new command is taken once all beats are handed on.
`include "light_macro_sequencer_core_defines.svh"

module light_macro_sequencer_core (
	input  logic          clk,
	input  logic          arst_n,
	lms_req_if.sink       req,
	lms_rsp_if.source     rsp,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data
);
	import lms_pkg::*;

	logic     loop_mode_q;
	lms_cmd_t cmd;
	logic     cmd_rdy;
	logic     res_vld;
	lms_res_t res;
	logic     res_rdy;
	logic     out_vld_q;
	lms_res_t out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			loop_mode_q <= cfg_wr_data;
		end
	end

	assign cmd.func    = req.func;
	assign cmd.address = req.address;
	assign cmd.data    = req.data;
	assign cmd.ms_tick = req.ms_tick;
	assign req.ready   = cmd_rdy;

	lms_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_vld   (req.valid),
		.cmd       (cmd),
		.cmd_rdy   (cmd_rdy),
		.loop_mode (loop_mode_q),
		.res_vld   (res_vld),
		.res       (res),
		.res_rdy   (res_rdy)
	);

	// output register
	assign res_rdy = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_rdy) begin
			out_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && res_vld) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.running         = out_q.running;
	assign rsp.sleeping        = out_q.sleeping;
	assign rsp.error_code      = out_q.error_code;
	assign rsp.program_counter = out_q.program_counter;
	assign rsp.dump_valid      = out_q.dump_valid;
	assign rsp.reg_index       = out_q.reg_index;
	assign rsp.reg_value       = out_q.reg_value;
	assign rsp.last            = out_q.last;

	// checks
	`LMS_ASSERT_IMP(a_dump_while_running, rsp.valid && rsp.dump_valid,
		rsp.running && !rsp.sleeping && !rsp.error_code)
	`LMS_ASSERT_IMP(a_error_stops, rsp.valid && rsp.error_code, !rsp.running)
	`LMS_ASSERT_IMP(a_status_is_last, rsp.valid && !rsp.dump_valid, rsp.last)
	`LMS_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
endmodule
